// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of the interpolator.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("concurrent assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("concurrent assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("concurrent assertion failed");

`endif

// File: rtl/bgi_pkg.sv
// Package of the bilinear grid interpolator: payload types, codes and
// fixed arithmetic constants. Depends on nothing.
`timescale 1ns / 1ps

package bgi_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Y = 1'b1;

   localparam logic [2:0] REQ_LOAD_X     = 3'd0;
   localparam logic [2:0] REQ_LOAD_Y     = 3'd1;
   localparam logic [2:0] REQ_LOAD_GRID  = 3'd2;
   localparam logic [2:0] REQ_EVAL_VALUE = 3'd3;
   localparam logic [2:0] REQ_EVAL_GRAD  = 3'd4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd1;
   localparam logic [1:0] STATUS_SATURATED  = 2'd2;

   localparam int WIDE_W     = 64;
   localparam int MUL_W      = 34;
   localparam int PROD_W     = WIDE_W + MUL_W;
   localparam int MUL_STEPS  = MUL_W;
   localparam int DIV_STEPS  = WIDE_W;
   localparam int QUEUE_DEPTH = 4;

   localparam logic signed [WIDE_W-1:0] WIDE_LIM = 64'sh2000_0000_0000_0000;
   localparam logic signed [MUL_W-1:0]  FRAC_ONE = 34'sd65536;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [11:0]        entry_index;
      logic signed [31:0] load_value;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] interp_value;
      logic signed [31:0] slope_x;
      logic signed [31:0] slope_y;
      logic [1:0]         status;
   } rsp_item_type;

   typedef enum logic [2:0] {
      OP_LOAD_X,
      OP_LOAD_Y,
      OP_LOAD_GRID,
      OP_EVAL_VALUE,
      OP_EVAL_GRAD
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [11:0]        index;
      logic signed [31:0] load_value;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
   } entry_type;

   typedef struct packed {
      logic                     start;
      logic signed [WIDE_W-1:0] a;
      logic signed [MUL_W-1:0]  b;
      logic signed [MUL_W-1:0]  c;
   } md_req_type;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [WIDE_W-1:0] q;
   } md_rsp_type;

endpackage

// File: rtl/bgi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bgi_front.sv
// Front end: accepts requests, classifies them and drops those that do nothing.
// Depends on bgi_pkg.
`timescale 1ns / 1ps

module bgi_front #(
   parameter int MAX_X_KNOTS = 64,
   parameter int MAX_Y_KNOTS = 64
) (
   input  logic                 req_push,
   output logic                 req_full,
   input  bgi_pkg::req_item_type req_data,
   input  logic                 q_full,
   output logic                 q_push,
   output bgi_pkg::entry_type    q_entry
);
   import bgi_pkg::*;

   localparam int GRID_DEPTH = MAX_X_KNOTS * MAX_Y_KNOTS;

   logic keep;

   always_comb begin
      q_entry.op         = OP_LOAD_X;
      q_entry.index      = req_data.entry_index;
      q_entry.load_value = req_data.load_value;
      q_entry.query_x    = req_data.query_x;
      q_entry.query_y    = req_data.query_y;
      keep               = 1'b0;
      unique case (req_data.req_type)
         REQ_LOAD_X: begin
            q_entry.op = OP_LOAD_X;
            keep       = 32'(req_data.entry_index) < 32'(MAX_X_KNOTS);
         end
         REQ_LOAD_Y: begin
            q_entry.op = OP_LOAD_Y;
            keep       = 32'(req_data.entry_index) < 32'(MAX_Y_KNOTS);
         end
         REQ_LOAD_GRID: begin
            q_entry.op = OP_LOAD_GRID;
            keep       = 32'(req_data.entry_index) < 32'(GRID_DEPTH);
         end
         REQ_EVAL_VALUE: begin
            q_entry.op = OP_EVAL_VALUE;
            keep       = 1'b1;
         end
         REQ_EVAL_GRAD: begin
            q_entry.op = OP_EVAL_GRAD;
            keep       = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full && keep;

endmodule

// File: rtl/bgi_queue.sv
// Short queue of classified requests between the front end and the back end.
// Depends on bgi_pkg.
`timescale 1ns / 1ps

module bgi_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bgi_pkg::entry_type entry_in,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output bgi_pkg::entry_type head
);
   import bgi_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = count_ff == CW'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// File: rtl/bgi_muldiv.sv
// Serial multiply-divide unit: a*b/c, exact product, truncated toward zero,
// clamped to the wide limit. Depends on bgi_pkg.
`timescale 1ns / 1ps

module bgi_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  bgi_pkg::md_req_type md_req,
   output bgi_pkg::md_rsp_type md_rsp
);
   import bgi_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      M_IDLE,
      M_MUL,
      M_CHECK,
      M_DIV,
      M_DONE
   } md_state_type;

   typedef struct packed {
      logic [WIDE_W-1:0] amag;
      logic [MUL_W-1:0]  bmag;
      logic [MUL_W-1:0]  dmag;
      logic              neg;
      logic [PROD_W-1:0] prod;
      logic [CNT_W-1:0]  cnt;
      logic [MUL_W:0]    rem;
      logic [WIDE_W-1:0] lo;
      logic [WIDE_W-1:0] quo;
   } md_ctx_type;

   md_state_type      state_ff, state_in;
   md_ctx_type        ctx_ff, ctx_in;
   logic [MUL_W-1:0]  hi_part;
   logic [MUL_W:0]    trial;
   logic [WIDE_W-1:0] quo_clamped;
   logic              quo_over;

   assign hi_part     = ctx_ff.prod[PROD_W-1:WIDE_W];
   assign trial       = {ctx_ff.rem[MUL_W-1:0], ctx_ff.lo[WIDE_W-1]};
   assign quo_over    = ctx_ff.quo > $unsigned(WIDE_LIM);
   assign quo_clamped = quo_over ? $unsigned(WIDE_LIM) : ctx_ff.quo;

   always_comb begin
      state_in = state_ff;
      ctx_in   = ctx_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (md_req.start) begin
               ctx_in.amag = md_req.a[WIDE_W-1] ? WIDE_W'(-md_req.a) : WIDE_W'(md_req.a);
               ctx_in.bmag = md_req.b[MUL_W-1] ? MUL_W'(-md_req.b) : MUL_W'(md_req.b);
               ctx_in.dmag = md_req.c[MUL_W-1] ? MUL_W'(-md_req.c) : MUL_W'(md_req.c);
               ctx_in.neg  = md_req.a[WIDE_W-1] ^ md_req.b[MUL_W-1] ^ md_req.c[MUL_W-1];
               ctx_in.prod = '0;
               ctx_in.cnt  = CNT_W'(MUL_STEPS - 1);
               state_in    = M_MUL;
            end
         end
         M_MUL: begin
            ctx_in.prod = (ctx_ff.prod << 1)
                        + (ctx_ff.bmag[MUL_W-1] ? PROD_W'(ctx_ff.amag) : '0);
            ctx_in.bmag = ctx_ff.bmag << 1;
            ctx_in.cnt  = ctx_ff.cnt - CNT_W'(1);
            if (ctx_ff.cnt == '0) begin
               state_in = M_CHECK;
            end
         end
         M_CHECK: begin
            if (hi_part >= ctx_ff.dmag) begin
               ctx_in.quo = $unsigned(WIDE_LIM) + WIDE_W'(1);
               state_in   = M_DONE;
            end else begin
               ctx_in.rem = {1'b0, hi_part};
               ctx_in.lo  = ctx_ff.prod[WIDE_W-1:0];
               ctx_in.quo = '0;
               ctx_in.cnt = CNT_W'(DIV_STEPS - 1);
               state_in   = M_DIV;
            end
         end
         M_DIV: begin
            if (trial >= {1'b0, ctx_ff.dmag}) begin
               ctx_in.rem = trial - {1'b0, ctx_ff.dmag};
               ctx_in.quo = {ctx_ff.quo[WIDE_W-2:0], 1'b1};
            end else begin
               ctx_in.rem = trial;
               ctx_in.quo = {ctx_ff.quo[WIDE_W-2:0], 1'b0};
            end
            ctx_in.lo  = ctx_ff.lo << 1;
            ctx_in.cnt = ctx_ff.cnt - CNT_W'(1);
            if (ctx_ff.cnt == '0) begin
               state_in = M_DONE;
            end
         end
         M_DONE: state_in = M_IDLE;
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ctx_ff <= ctx_in;
   end

   assign md_rsp.done = state_ff == M_DONE;
   assign md_rsp.sat  = quo_over;
   assign md_rsp.q    = ctx_ff.neg ? -$signed(quo_clamped) : $signed(quo_clamped);

endmodule

// File: rtl/bgi_back.sv
// Back end: executes table loads, searches both axes, fetches the cell and
// runs the interpolation through the serial multiply-divide unit.
// Depends on bgi_pkg, bgi_ram and bgi_muldiv.
`timescale 1ns / 1ps

module bgi_back #(
   parameter int MAX_X_KNOTS = 64,
   parameter int MAX_Y_KNOTS = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [bgi_pkg::CSR_DATA_W-1:0] size_x,
   input  logic [bgi_pkg::CSR_DATA_W-1:0] size_y,
   input  logic                  q_empty,
   input  bgi_pkg::entry_type    q_head,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output bgi_pkg::rsp_item_type rsp_data
);
   import bgi_pkg::*;

   localparam int XAW        = $clog2(MAX_X_KNOTS);
   localparam int YAW        = $clog2(MAX_Y_KNOTS);
   localparam int XSW        = $clog2(MAX_X_KNOTS + 1);
   localparam int YSW        = $clog2(MAX_Y_KNOTS + 1);
   localparam int GRID_DEPTH = MAX_X_KNOTS * MAX_Y_KNOTS;
   localparam int GAW        = $clog2(GRID_DEPTH);
   localparam int BPW        = XAW + YSW + 1;
   localparam int SAT_BITS   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam logic signed [WIDE_W-1:0] SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - 64'sd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_KNOT_LO,
      ST_KNOT_HI,
      ST_KNOT_CAP,
      ST_WIDTH,
      ST_GRID,
      ST_MD_START,
      ST_MD_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      STEP_A0,
      STEP_A1,
      STEP_VALUE,
      STEP_C0,
      STEP_C1,
      STEP_SLOPE_X,
      STEP_SLOPE_Y
   } step_type;

   typedef struct packed {
      entry_type          cur;
      logic [XAW-1:0]     lo_x;
      logic [XAW-1:0]     hi_x;
      logic [XAW-1:0]     mid_x;
      logic               act_x;
      logic [YAW-1:0]     lo_y;
      logic [YAW-1:0]     hi_y;
      logic [YAW-1:0]     mid_y;
      logic               act_y;
      logic signed [31:0] x0;
      logic signed [31:0] x1;
      logic signed [31:0] y0;
      logic signed [31:0] y1;
      logic [GAW-1:0]     base;
      logic [2:0]         gcnt;
      logic signed [31:0] z00;
      logic signed [31:0] z01;
      logic signed [31:0] z10;
      logic signed [31:0] z11;
      step_type           step;
      logic signed [WIDE_W-1:0] a0;
      logic signed [WIDE_W-1:0] a1;
      logic signed [WIDE_W-1:0] c0;
      logic signed [WIDE_W-1:0] c1;
      logic signed [31:0] val;
      logic signed [31:0] sxo;
      logic signed [31:0] syo;
      logic               sat;
      logic               zero;
   } ctx_type;

   state_type    state_ff, state_in;
   ctx_type      ctx_ff, ctx_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_data_ff, out_data_in;

   logic [XSW-1:0] esx;
   logic [YSW-1:0] esy;
   logic [XAW-1:0] mid_x_calc;
   logic [YAW-1:0] mid_y_calc;
   logic           act_x_calc, act_y_calc;

   logic           x_we, y_we, g_we;
   logic [XAW-1:0] x_raddr;
   logic [YAW-1:0] y_raddr;
   logic [GAW-1:0] g_raddr;
   logic [31:0]    x_rdata, y_rdata, g_rdata;

   logic signed [32:0]       wx, wy, ex, ey;
   logic signed [WIDE_W-1:0] w00, w01, w10, w11;
   logic signed [WIDE_W-1:0] op_base, op_a;
   logic signed [MUL_W-1:0]  op_b, op_c;
   logic signed [WIDE_W-1:0] sum, wide_c, out_c;
   logic                     wide_sat, out_sat;
   md_req_type               md_req;
   md_rsp_type               md_rsp;

   bgi_ram #(.WIDTH(32), .DEPTH(MAX_X_KNOTS)) u_x_ram (
      .clock (clock),
      .we    (x_we),
      .waddr (XAW'(q_head.index)),
      .wdata (q_head.load_value),
      .raddr (x_raddr),
      .rdata (x_rdata)
   );

   bgi_ram #(.WIDTH(32), .DEPTH(MAX_Y_KNOTS)) u_y_ram (
      .clock (clock),
      .we    (y_we),
      .waddr (YAW'(q_head.index)),
      .wdata (q_head.load_value),
      .raddr (y_raddr),
      .rdata (y_rdata)
   );

   bgi_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid_ram (
      .clock (clock),
      .we    (g_we),
      .waddr (GAW'(q_head.index)),
      .wdata (q_head.load_value),
      .raddr (g_raddr),
      .rdata (g_rdata)
   );

   bgi_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_comb begin
      if (size_x < CSR_DATA_W'(2)) begin
         esx = XSW'(2);
      end else if (32'(size_x) > 32'(MAX_X_KNOTS)) begin
         esx = XSW'(MAX_X_KNOTS);
      end else begin
         esx = XSW'(size_x);
      end
      if (size_y < CSR_DATA_W'(2)) begin
         esy = YSW'(2);
      end else if (32'(size_y) > 32'(MAX_Y_KNOTS)) begin
         esy = YSW'(MAX_Y_KNOTS);
      end else begin
         esy = YSW'(size_y);
      end
   end

   assign act_x_calc = {1'b0, ctx_ff.hi_x} > ({1'b0, ctx_ff.lo_x} + (XAW + 1)'(1));
   assign act_y_calc = {1'b0, ctx_ff.hi_y} > ({1'b0, ctx_ff.lo_y} + (YAW + 1)'(1));
   assign mid_x_calc = XAW'(({1'b0, ctx_ff.lo_x} + {1'b0, ctx_ff.hi_x}) >> 1);
   assign mid_y_calc = YAW'(({1'b0, ctx_ff.lo_y} + {1'b0, ctx_ff.hi_y}) >> 1);

   assign wx = {ctx_ff.x1[31], ctx_ff.x1} - {ctx_ff.x0[31], ctx_ff.x0};
   assign wy = {ctx_ff.y1[31], ctx_ff.y1} - {ctx_ff.y0[31], ctx_ff.y0};
   assign ex = {ctx_ff.cur.query_x[31], ctx_ff.cur.query_x} - {ctx_ff.x0[31], ctx_ff.x0};
   assign ey = {ctx_ff.cur.query_y[31], ctx_ff.cur.query_y} - {ctx_ff.y0[31], ctx_ff.y0};
   assign w00 = {{32{ctx_ff.z00[31]}}, ctx_ff.z00};
   assign w01 = {{32{ctx_ff.z01[31]}}, ctx_ff.z01};
   assign w10 = {{32{ctx_ff.z10[31]}}, ctx_ff.z10};
   assign w11 = {{32{ctx_ff.z11[31]}}, ctx_ff.z11};

   always_comb begin
      op_base = '0;
      op_a    = '0;
      op_b    = FRAC_ONE;
      op_c    = {wx[32], wx};
      case (ctx_ff.step)
         STEP_A0: begin
            op_base = w00;
            op_a    = w01 - w00;
            op_b    = {ey[32], ey};
            op_c    = {wy[32], wy};
         end
         STEP_A1: begin
            op_base = w10;
            op_a    = w11 - w10;
            op_b    = {ey[32], ey};
            op_c    = {wy[32], wy};
         end
         STEP_VALUE: begin
            op_base = ctx_ff.a0;
            op_a    = ctx_ff.a1 - ctx_ff.a0;
            op_b    = {ex[32], ex};
         end
         STEP_C0: begin
            op_base = w00;
            op_a    = w10 - w00;
            op_b    = {ex[32], ex};
         end
         STEP_C1: begin
            op_base = w01;
            op_a    = w11 - w01;
            op_b    = {ex[32], ex};
         end
         STEP_SLOPE_X: begin
            op_a = ctx_ff.a1 - ctx_ff.a0;
         end
         STEP_SLOPE_Y: begin
            op_a = ctx_ff.c1 - ctx_ff.c0;
            op_c = {wy[32], wy};
         end
         default: op_a = '0;
      endcase
   end

   assign sum = op_base + md_rsp.q;

   always_comb begin
      wide_sat = 1'b0;
      wide_c   = sum;
      if (sum > WIDE_LIM) begin
         wide_sat = 1'b1;
         wide_c   = WIDE_LIM;
      end else if (sum < -WIDE_LIM) begin
         wide_sat = 1'b1;
         wide_c   = -WIDE_LIM;
      end
      out_sat = 1'b0;
      out_c   = wide_c;
      if (wide_c > SAT_HI) begin
         out_sat = 1'b1;
         out_c   = SAT_HI;
      end else if (wide_c < SAT_LO) begin
         out_sat = 1'b1;
         out_c   = SAT_LO;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      x_we         = 1'b0;
      y_we         = 1'b0;
      g_we         = 1'b0;
      md_req       = '0;
      x_raddr      = mid_x_calc;
      y_raddr      = mid_y_calc;
      case (ctx_ff.gcnt)
         3'd1:    g_raddr = ctx_ff.base + GAW'(1);
         3'd2:    g_raddr = ctx_ff.base + GAW'(esy);
         3'd3:    g_raddr = ctx_ff.base + GAW'(esy) + GAW'(1);
         default: g_raddr = ctx_ff.base;
      endcase
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_head.op)
                  OP_LOAD_X:    x_we = 1'b1;
                  OP_LOAD_Y:    y_we = 1'b1;
                  OP_LOAD_GRID: g_we = 1'b1;
                  OP_EVAL_VALUE, OP_EVAL_GRAD: begin
                     ctx_in.cur  = q_head;
                     ctx_in.lo_x = '0;
                     ctx_in.hi_x = XAW'(esx - XSW'(1));
                     ctx_in.lo_y = '0;
                     ctx_in.hi_y = YAW'(esy - YSW'(1));
                     ctx_in.val  = '0;
                     ctx_in.sxo  = '0;
                     ctx_in.syo  = '0;
                     ctx_in.sat  = 1'b0;
                     ctx_in.zero = 1'b0;
                     state_in    = ST_SEARCH;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         ST_SEARCH: begin
            ctx_in.mid_x = mid_x_calc;
            ctx_in.mid_y = mid_y_calc;
            ctx_in.act_x = act_x_calc;
            ctx_in.act_y = act_y_calc;
            state_in     = (act_x_calc || act_y_calc) ? ST_COMPARE : ST_KNOT_LO;
         end
         ST_COMPARE: begin
            if (ctx_ff.act_x) begin
               if ($signed(x_rdata) > ctx_ff.cur.query_x) begin
                  ctx_in.hi_x = ctx_ff.mid_x;
               end else begin
                  ctx_in.lo_x = ctx_ff.mid_x;
               end
            end
            if (ctx_ff.act_y) begin
               if ($signed(y_rdata) > ctx_ff.cur.query_y) begin
                  ctx_in.hi_y = ctx_ff.mid_y;
               end else begin
                  ctx_in.lo_y = ctx_ff.mid_y;
               end
            end
            state_in = ST_SEARCH;
         end
         ST_KNOT_LO: begin
            x_raddr  = ctx_ff.lo_x;
            y_raddr  = ctx_ff.lo_y;
            state_in = ST_KNOT_HI;
         end
         ST_KNOT_HI: begin
            x_raddr   = ctx_ff.lo_x + XAW'(1);
            y_raddr   = ctx_ff.lo_y + YAW'(1);
            ctx_in.x0 = $signed(x_rdata);
            ctx_in.y0 = $signed(y_rdata);
            state_in  = ST_KNOT_CAP;
         end
         ST_KNOT_CAP: begin
            ctx_in.x1   = $signed(x_rdata);
            ctx_in.y1   = $signed(y_rdata);
            ctx_in.base = GAW'(BPW'(ctx_ff.lo_x) * BPW'(esy) + BPW'(ctx_ff.lo_y));
            state_in    = ST_WIDTH;
         end
         ST_WIDTH: begin
            if (wx == '0 || wy == '0) begin
               ctx_in.zero = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               ctx_in.gcnt = '0;
               state_in    = ST_GRID;
            end
         end
         ST_GRID: begin
            case (ctx_ff.gcnt)
               3'd1:    ctx_in.z00 = $signed(g_rdata);
               3'd2:    ctx_in.z01 = $signed(g_rdata);
               3'd3:    ctx_in.z10 = $signed(g_rdata);
               3'd4:    ctx_in.z11 = $signed(g_rdata);
               default: ctx_in.z00 = ctx_ff.z00;
            endcase
            ctx_in.gcnt = ctx_ff.gcnt + 3'd1;
            if (ctx_ff.gcnt == 3'd4) begin
               ctx_in.step = STEP_A0;
               state_in    = ST_MD_START;
            end
         end
         ST_MD_START: begin
            md_req.start = 1'b1;
            md_req.a     = op_a;
            md_req.b     = op_b;
            md_req.c     = op_c;
            state_in     = ST_MD_WAIT;
         end
         ST_MD_WAIT: begin
            if (md_rsp.done) begin
               ctx_in.sat = ctx_ff.sat || md_rsp.sat || wide_sat;
               state_in   = ST_MD_START;
               case (ctx_ff.step)
                  STEP_A0: begin
                     ctx_in.a0   = wide_c;
                     ctx_in.step = STEP_A1;
                  end
                  STEP_A1: begin
                     ctx_in.a1   = wide_c;
                     ctx_in.step = (ctx_ff.cur.op == OP_EVAL_VALUE) ? STEP_VALUE : STEP_C0;
                  end
                  STEP_VALUE: begin
                     ctx_in.val = out_c[31:0];
                     ctx_in.sat = ctx_ff.sat || md_rsp.sat || wide_sat || out_sat;
                     state_in   = ST_FINISH;
                  end
                  STEP_C0: begin
                     ctx_in.c0   = wide_c;
                     ctx_in.step = STEP_C1;
                  end
                  STEP_C1: begin
                     ctx_in.c1   = wide_c;
                     ctx_in.step = STEP_SLOPE_X;
                  end
                  STEP_SLOPE_X: begin
                     ctx_in.sxo  = out_c[31:0];
                     ctx_in.sat  = ctx_ff.sat || md_rsp.sat || wide_sat || out_sat;
                     ctx_in.step = STEP_SLOPE_Y;
                  end
                  default: begin
                     ctx_in.syo = out_c[31:0];
                     ctx_in.sat = ctx_ff.sat || md_rsp.sat || wide_sat || out_sat;
                     state_in   = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff) begin
               out_valid_in             = 1'b1;
               out_data_in.interp_value = ctx_ff.val;
               out_data_in.slope_x      = ctx_ff.sxo;
               out_data_in.slope_y      = ctx_ff.syo;
               out_data_in.status       = ctx_ff.zero ? STATUS_ZERO_WIDTH :
                                          ctx_ff.sat  ? STATUS_SATURATED  : STATUS_OK;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      ctx_ff      <= ctx_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: rtl/bilinear_grid_interpolator_top.sv
// Top level of the bilinear grid interpolator: size registers, front end,
// request queue and back end. Depends on bgi_pkg, bgi_front, bgi_queue, bgi_back.
`timescale 1ns / 1ps

// Requests enter through a four-entry queue and are carried out one at a
// time by the back end. A load is written to its table from the head of the
// queue. A query runs the binary search on both axes together, each step a
// search state and a compare state, then fetches knots and cell samples,
// and then runs through one serial multiply-divide unit for each quotient
// (34 multiply steps, 64 divide steps). A finished result waits in an
// output register while further requests are taken into the queue.

module bilinear_grid_interpolator_top #(
   parameter int MAX_X_KNOTS = 64,
   parameter int MAX_Y_KNOTS = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  bgi_pkg::req_item_type               req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output bgi_pkg::rsp_item_type               rsp_data,
   input  logic                                csr_we,
   input  logic [bgi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bgi_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bgi_pkg::*;

   logic [CSR_DATA_W-1:0] size_x_ff, size_x_in;
   logic [CSR_DATA_W-1:0] size_y_ff, size_y_in;
   logic                  q_push, q_full, q_pop, q_empty;
   entry_type             q_entry, q_head;

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_in = csr_wdata;
            CSR_SIZE_Y: size_y_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= CSR_DATA_W'(2);
         size_y_ff <= CSR_DATA_W'(2);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
      end
   end

   bgi_front #(
      .MAX_X_KNOTS (MAX_X_KNOTS),
      .MAX_Y_KNOTS (MAX_Y_KNOTS)
   ) u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   bgi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_entry),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   bgi_back #(
      .MAX_X_KNOTS (MAX_X_KNOTS),
      .MAX_Y_KNOTS (MAX_Y_KNOTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .size_x    (size_x_ff),
      .size_y    (size_y_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/bgi_checker.sv
// Port-level checker of the interpolator and the bind that attaches it.
// Depends on bgi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bgi_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input bgi_pkg::rsp_item_type rsp_data
);
   import bgi_pkg::*;

   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty && !req_full)

   `ASSERT_NEXT(a_stall_holds, clock, reset, !rsp_empty && !rsp_pop,
                !rsp_empty && $stable(rsp_data))

   `ASSERT_IMPLIES(a_status_code, clock, reset, !rsp_empty, rsp_data.status != 2'd3)

   `ASSERT_IMPLIES(a_zero_width_clear, clock, reset,
                   !rsp_empty && rsp_data.status == STATUS_ZERO_WIDTH,
                   rsp_data.interp_value == '0 && rsp_data.slope_x == '0 &&
                   rsp_data.slope_y == '0)

   `ASSERT_IMPLIES(a_one_kind, clock, reset, !rsp_empty && rsp_data.interp_value != '0,
                   rsp_data.slope_x == '0 && rsp_data.slope_y == '0)

endmodule

bind bilinear_grid_interpolator_top bgi_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// File: test/bilinear_grid_interpolator_top_tb.sv
// Self-checking testbench of bilinear_grid_interpolator_top: knot and sample loads, then
// value and gradient queries checked against a predictor kept in a scoreboard class.
// Depends on bgi_pkg and the interpolator RTL.
`timescale 1ns / 1ps

module bilinear_grid_interpolator_top_tb;
   import bgi_pkg::*;

   localparam longint SPAN = 64'sd1 <<< 61;
   localparam int TARGET_ITEMS = 1050;
   localparam longint CYCLE_LIMIT = 3000000;

   class grid_scoreboard;
      logic signed [31:0] x_knot[64];
      logic signed [31:0] y_knot[64];
      logic signed [31:0] sample[4096];
      bit sample_set[4096];
      logic [6:0] size_x = 7'd2;
      logic [6:0] size_y = 7'd2;
      rsp_item_type pending[$];
      int errors = 0;
      bit clipped;

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      function int eff(logic [6:0] r);
         if (r < 2) return 2;
         if (r > 64) return 64;
         return int'(r);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [6:0] v);
         if (idx == CSR_SIZE_X) size_x = v;
         else size_y = v;
      endfunction

      function int search(bit on_y, longint v);
         int lo, hi, m;
         lo = 0;
         hi = eff(on_y ? size_y : size_x) - 1;
         while (hi > lo + 1) begin
            m = (lo + hi) / 2;
            if (longint'(on_y ? y_knot[m] : x_knot[m]) > v) hi = m;
            else lo = m;
         end
         return lo;
      endfunction

      function longint scale_div(longint a, longint b, longint c);
         logic [63:0] ma, mb, md;
         logic [127:0] q;
         bit neg;
         neg = ((a < 0) ^ (b < 0)) ^ (c < 0);
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         md = (c < 0) ? -c : c;
         q = ({64'd0, ma} * {64'd0, mb}) / {64'd0, md};
         if (q > 128'(SPAN)) begin
            clipped = 1;
            q = 128'(SPAN);
         end
         return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
      endfunction

      function longint clamp_wide(longint v);
         if (v > SPAN) begin clipped = 1; return SPAN; end
         if (v < -SPAN) begin clipped = 1; return -SPAN; end
         return v;
      endfunction

      function logic signed [31:0] clamp_out(longint v);
         if (v > 64'sd2147483647) begin clipped = 1; return 32'sh7fffffff; end
         if (v < -64'sd2147483648) begin clipped = 1; return 32'sh80000000; end
         return v[31:0];
      endfunction

      function rsp_item_type predict(req_item_type it);
         rsp_item_type r;
         int ix, iy, sy, b0, b1;
         longint x0, x1, y0, y1, wx, wy, ex, ey, z00, z01, z10, z11, a0, a1, c0, c1;
         r = '0;
         sy = eff(size_y);
         ix = search(0, it.query_x);
         iy = search(1, it.query_y);
         x0 = x_knot[ix]; x1 = x_knot[ix + 1];
         y0 = y_knot[iy]; y1 = y_knot[iy + 1];
         wx = x1 - x0;
         wy = y1 - y0;
         if (wx == 0 || wy == 0) begin
            r.status = STATUS_ZERO_WIDTH;
            return r;
         end
         b0 = ix * sy + iy;
         b1 = b0 + sy;
         z00 = sample[b0]; z01 = sample[b0 + 1];
         z10 = sample[b1]; z11 = sample[b1 + 1];
         ex = longint'(it.query_x) - x0;
         ey = longint'(it.query_y) - y0;
         clipped = 0;
         a0 = clamp_wide(z00 + scale_div(z01 - z00, ey, wy));
         a1 = clamp_wide(z10 + scale_div(z11 - z10, ey, wy));
         if (it.req_type == REQ_EVAL_VALUE) begin
            r.interp_value = clamp_out(clamp_wide(a0 + scale_div(a1 - a0, ex, wx)));
         end else begin
            c0 = clamp_wide(z00 + scale_div(z10 - z00, ex, wx));
            c1 = clamp_wide(z01 + scale_div(z11 - z01, ex, wx));
            r.slope_x = clamp_out(scale_div(a1 - a0, 65536, wx));
            r.slope_y = clamp_out(scale_div(c1 - c0, 65536, wy));
         end
         r.status = clipped ? STATUS_SATURATED : STATUS_OK;
         return r;
      endfunction

      function void note(req_item_type it);
         case (it.req_type)
            REQ_LOAD_X: if (it.entry_index < 64) x_knot[it.entry_index] = it.load_value;
            REQ_LOAD_Y: if (it.entry_index < 64) y_knot[it.entry_index] = it.load_value;
            REQ_LOAD_GRID: begin
               sample[it.entry_index] = it.load_value;
               sample_set[it.entry_index] = 1;
            end
            REQ_EVAL_VALUE, REQ_EVAL_GRAD: pending.push_back(predict(it));
            default: ;
         endcase
      endfunction

      task check(rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = pending.pop_front();
         if (got.interp_value !== want.interp_value)
            report($sformatf("interp_value %h, expected %h", got.interp_value,
                             want.interp_value));
         if (got.slope_x !== want.slope_x)
            report($sformatf("slope_x %h, expected %h", got.slope_x, want.slope_x));
         if (got.slope_y !== want.slope_y)
            report($sformatf("slope_y %h, expected %h", got.slope_y, want.slope_y));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   req_item_type req_data;
   logic rsp_empty;
   logic rsp_pop;
   rsp_item_type rsp_data;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   grid_scoreboard sb = new();
   int sent = 0;
   int popped = 0;
   bit quiet_tx = 0;
   bit quiet_rx = 0;
   bit wide_samples = 0;
   longint cycles = 0;

   bilinear_grid_interpolator_top u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("bilinear_grid_interpolator_top: mismatch");
         $finish;
      end
   end

   function automatic req_item_type make_item(logic [2:0] kind, logic [11:0] idx,
                                              logic [31:0] val, logic [31:0] qx,
                                              logic [31:0] qy);
      req_item_type it;
      it.req_type = kind;
      it.entry_index = idx;
      it.load_value = val;
      it.query_x = qx;
      it.query_y = qy;
      return it;
   endfunction

   function automatic logic [31:0] sample_value();
      if (wide_samples) return $urandom;
      return $urandom_range(0, 1 << 21) - (1 << 20);
   endfunction

   task automatic push_item(req_item_type it);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      sb.note(it);
      sent++;
   endtask

   task automatic load(logic [2:0] kind, int idx, logic [31:0] val);
      push_item(make_item(kind, 12'(idx), val, $urandom, $urandom));
   endtask

   task automatic settle();
      @(negedge clock);
      req_push <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [6:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic load_knots(logic [2:0] kind, int n, int mode);
      longint v, step_max;
      v = -longint'($urandom_range(0, 1 << 30));
      step_max = 64'd1 << (2 + 11 * $urandom_range(0, 2));
      for (int i = 0; i < n; i++) begin
         if (mode == 2) load(kind, i, $urandom);
         else load(kind, i, v[31:0]);
         if (mode == 1 && $urandom_range(0, 3) == 0) v = v;
         else v += $urandom_range(1, 32'(step_max));
      end
   endtask

   task automatic query(logic [2:0] kind, logic [31:0] qx, logic [31:0] qy);
      int ix, iy, sy, b0, b1;
      int cells[4];
      ix = sb.search(0, $signed(qx));
      iy = sb.search(1, $signed(qy));
      sy = sb.eff(sb.size_y);
      b0 = ix * sy + iy;
      b1 = b0 + sy;
      cells = '{b0, b0 + 1, b1, b1 + 1};
      foreach (cells[k])
         if (!sb.sample_set[cells[k]]) load(REQ_LOAD_GRID, cells[k], sample_value());
      push_item(make_item(kind, 12'($urandom), $urandom, qx, qy));
   endtask

   function automatic logic [31:0] coord(bit on_y);
      longint a, b, lo, hi, span, v;
      int n;
      if ($urandom_range(0, 9) < 3) return $urandom;
      n = sb.eff(on_y ? sb.size_y : sb.size_x);
      a = on_y ? sb.y_knot[0] : sb.x_knot[0];
      b = on_y ? sb.y_knot[n - 1] : sb.x_knot[n - 1];
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      span = (hi - lo) / 4 + 16;
      v = lo - span + longint'({$urandom, $urandom} % (hi - lo + 2 * span + 1));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   initial begin
      int gap;
      bit held;
      held = 0;
      rsp_pop = 0;
      @(negedge reset);
      forever begin
         gap = quiet_rx ? 0 : $urandom_range(0, 5);
         if (popped == 50 && !held) begin
            held = 1;
            gap = 4000;
         end
         if (popped % 100 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
         @(negedge clock);
         if (gap > 0) begin
            rsp_pop <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1;
         do @(posedge clock); while (rsp_empty);
         sb.check(rsp_data);
         popped++;
      end
   end

   initial begin
      int phase, sx, sy, nq, pick, mode;
      logic [6:0] rx, ry;
      reset = 1;
      req_push = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      write_csr(CSR_SIZE_X, 7'd2);
      write_csr(CSR_SIZE_Y, 7'd2);
      load(REQ_LOAD_X, 0, 0);
      load(REQ_LOAD_X, 1, 32'sd65536);
      load(REQ_LOAD_Y, 0, 0);
      load(REQ_LOAD_Y, 1, 32'sd65536);
      load(REQ_LOAD_GRID, 0, 0);
      load(REQ_LOAD_GRID, 1, 32'sd65536);
      load(REQ_LOAD_GRID, 2, 32'sd131072);
      load(REQ_LOAD_GRID, 3, -32'sd65536);
      query(REQ_EVAL_VALUE, 32'sd32768, 32'sd32768);
      query(REQ_EVAL_GRAD, 32'sd32768, 32'sd32768);
      query(REQ_EVAL_VALUE, 32'sh7fffffff, 32'sh80000000);
      query(REQ_EVAL_GRAD, 32'sh80000000, 32'sh7fffffff);
      for (int k = 1; k <= 3; k++) push_item(make_item(3'(REQ_EVAL_GRAD + k), 12'($urandom),
                                                       $urandom, $urandom, $urandom));
      load(REQ_LOAD_X, 64, 32'sh7fffffff);
      load(REQ_LOAD_Y, 4095, 32'sh80000000);
      load(REQ_LOAD_GRID, 0, 32'sh7fffffff);
      load(REQ_LOAD_GRID, 3, 32'sh80000000);
      query(REQ_EVAL_VALUE, 32'sh7fffffff, 0);
      query(REQ_EVAL_GRAD, 32'sh7fffffff, 32'sh80000000);
      load(REQ_LOAD_X, 1, 0);
      query(REQ_EVAL_VALUE, 32'sd100, 32'sd100);
      load(REQ_LOAD_X, 1, 32'sd65536);

      phase = 0;
      while (sent < TARGET_ITEMS) begin
         settle();
         case (phase)
            0: begin rx = 7'd0; ry = 7'd1; end
            1: begin rx = 7'd127; ry = 7'd64; end
            2: begin rx = 7'd64; ry = 7'd127; end
            default: begin
               rx = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(2, 8));
               ry = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(2, 8));
            end
         endcase
         write_csr(CSR_SIZE_X, rx);
         write_csr(CSR_SIZE_Y, ry);
         sx = sb.eff(rx);
         sy = sb.eff(ry);
         quiet_tx = ($urandom_range(0, 3) == 0);
         wide_samples = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         mode = pick < 8 ? 0 : pick - 7;
         load_knots(REQ_LOAD_X, sx, mode);
         load_knots(REQ_LOAD_Y, sy, $urandom_range(0, 9) < 8 ? 0 : $urandom_range(1, 2));
         if (sx * sy <= 64)
            for (int i = 0; i < sx * sy; i++) load(REQ_LOAD_GRID, i, sample_value());
         nq = $urandom_range(8, 24);
         repeat (nq) begin
            pick = $urandom_range(0, 19);
            case (pick)
               0: push_item(make_item(3'(REQ_EVAL_GRAD + $urandom_range(1, 3)),
                                      12'($urandom), $urandom, $urandom, $urandom));
               1: load($urandom_range(0, 1) ? REQ_LOAD_X : REQ_LOAD_Y,
                       $urandom_range(64, 4095), $urandom);
               2: load($urandom_range(0, 1) ? REQ_LOAD_X : REQ_LOAD_Y,
                       $urandom_range(0, 63), $urandom);
               3: load(REQ_LOAD_GRID, $urandom_range(0, 4095), sample_value());
               default: query($urandom_range(0, 1) ? REQ_EVAL_VALUE : REQ_EVAL_GRAD,
                              coord(0), coord(1));
            endcase
         end
         phase++;
      end

      settle();
      repeat (1000) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("bilinear_grid_interpolator_top: match");
      else
         $display("bilinear_grid_interpolator_top: mismatch");
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/bgi_pkg.sv
rtl/bgi_ram.sv
rtl/bgi_front.sv
rtl/bgi_queue.sv
rtl/bgi_muldiv.sv
rtl/bgi_back.sv
rtl/bilinear_grid_interpolator_top.sv
rtl/bgi_checker.sv
test/bilinear_grid_interpolator_top_tb.sv
